@@ src/bcf_pkg.sv @@
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types, float constants and the microcode program for the
// incomplete-beta continued-fraction core.
// ----------------------------------------------------------------------------
package bcf_pkg;

  localparam logic [7:0]  MAX_ITERATIONS = 8'd100;

  localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
  localparam logic [31:0] FP_TINY   = 32'h0DA2_4260;
  localparam logic [31:0] FP_EPS    = 32'h34A1_0FB0;
  localparam logic [31:0] FP_QNAN   = 32'h7FC0_0000;
  localparam logic [31:0] FP_DEFNAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET  = 32'h0040_0000;

  typedef enum logic [3:0] {
    OP_LDA, OP_LDB, OP_LDX, OP_LDONE, OP_LDFM, OP_LDFM2,
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG, OP_CLAMP, OP_PASS, OP_TEST
  } op_t;

  typedef enum logic [3:0] {
    R_A, R_B, R_X, R_ONE, R_C, R_D, R_H, R_QAB,
    R_QAP, R_QAM, R_T1, R_T2, R_AA, R_FM, R_FM2, R_AF2
  } reg_t;

  typedef struct packed {
    op_t  op;
    reg_t dst;
    reg_t sa;
    reg_t sb;
  } uop_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [31:0] opa;
    logic [31:0] opb;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fpu_rsp_t;

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_READ, S_WAIT, S_OUT} seq_state_t;

  typedef enum logic [2:0] {F_IDLE, F_UNPK, F_CALC, F_DIV, F_ROUND, F_DONE} fpu_state_t;

  localparam int          PC_W    = 6;
  localparam logic [5:0]  LOOP_PC = 6'd14;

  function automatic uop_t mk(op_t op, reg_t dst, reg_t sa, reg_t sb);
    uop_t u;
    u.op  = op;
    u.dst = dst;
    u.sa  = sa;
    u.sb  = sb;
    return u;
  endfunction

  function automatic uop_t prog_rom(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:    u = mk(OP_LDA,   R_A,   R_A,   R_A);
      6'd1:    u = mk(OP_LDB,   R_B,   R_A,   R_A);
      6'd2:    u = mk(OP_LDX,   R_X,   R_A,   R_A);
      6'd3:    u = mk(OP_LDONE, R_ONE, R_A,   R_A);
      6'd4:    u = mk(OP_LDONE, R_C,   R_A,   R_A);
      6'd5:    u = mk(OP_ADD,   R_QAB, R_A,   R_B);
      6'd6:    u = mk(OP_ADD,   R_QAP, R_A,   R_ONE);
      6'd7:    u = mk(OP_SUB,   R_QAM, R_A,   R_ONE);
      6'd8:    u = mk(OP_MUL,   R_T1,  R_QAB, R_X);
      6'd9:    u = mk(OP_DIV,   R_T1,  R_T1,  R_QAP);
      6'd10:   u = mk(OP_SUB,   R_D,   R_ONE, R_T1);
      6'd11:   u = mk(OP_CLAMP, R_D,   R_D,   R_D);
      6'd12:   u = mk(OP_DIV,   R_D,   R_ONE, R_D);
      6'd13:   u = mk(OP_PASS,  R_H,   R_D,   R_D);
      6'd14:   u = mk(OP_LDFM,  R_FM,  R_A,   R_A);
      6'd15:   u = mk(OP_LDFM2, R_FM2, R_A,   R_A);
      6'd16:   u = mk(OP_SUB,   R_T1,  R_B,   R_FM);
      6'd17:   u = mk(OP_MUL,   R_T1,  R_FM,  R_T1);
      6'd18:   u = mk(OP_MUL,   R_T1,  R_T1,  R_X);
      6'd19:   u = mk(OP_ADD,   R_T2,  R_QAM, R_FM2);
      6'd20:   u = mk(OP_ADD,   R_AF2, R_A,   R_FM2);
      6'd21:   u = mk(OP_MUL,   R_T2,  R_T2,  R_AF2);
      6'd22:   u = mk(OP_DIV,   R_AA,  R_T1,  R_T2);
      6'd23:   u = mk(OP_MUL,   R_T1,  R_AA,  R_D);
      6'd24:   u = mk(OP_ADD,   R_T1,  R_ONE, R_T1);
      6'd25:   u = mk(OP_CLAMP, R_D,   R_T1,  R_T1);
      6'd26:   u = mk(OP_DIV,   R_T1,  R_AA,  R_C);
      6'd27:   u = mk(OP_ADD,   R_T1,  R_ONE, R_T1);
      6'd28:   u = mk(OP_CLAMP, R_C,   R_T1,  R_T1);
      6'd29:   u = mk(OP_DIV,   R_D,   R_ONE, R_D);
      6'd30:   u = mk(OP_MUL,   R_T1,  R_D,   R_C);
      6'd31:   u = mk(OP_MUL,   R_H,   R_H,   R_T1);
      6'd32:   u = mk(OP_ADD,   R_T1,  R_A,   R_FM);
      6'd33:   u = mk(OP_NEG,   R_T1,  R_T1,  R_T1);
      6'd34:   u = mk(OP_ADD,   R_T2,  R_QAB, R_FM);
      6'd35:   u = mk(OP_MUL,   R_T1,  R_T1,  R_T2);
      6'd36:   u = mk(OP_MUL,   R_T1,  R_T1,  R_X);
      6'd37:   u = mk(OP_ADD,   R_T2,  R_QAP, R_FM2);
      6'd38:   u = mk(OP_MUL,   R_T2,  R_AF2, R_T2);
      6'd39:   u = mk(OP_DIV,   R_AA,  R_T1,  R_T2);
      6'd40:   u = mk(OP_MUL,   R_T1,  R_AA,  R_D);
      6'd41:   u = mk(OP_ADD,   R_T1,  R_ONE, R_T1);
      6'd42:   u = mk(OP_CLAMP, R_D,   R_T1,  R_T1);
      6'd43:   u = mk(OP_DIV,   R_T1,  R_AA,  R_C);
      6'd44:   u = mk(OP_ADD,   R_T1,  R_ONE, R_T1);
      6'd45:   u = mk(OP_CLAMP, R_C,   R_T1,  R_T1);
      6'd46:   u = mk(OP_DIV,   R_D,   R_ONE, R_D);
      6'd47:   u = mk(OP_MUL,   R_T1,  R_D,   R_C);
      6'd48:   u = mk(OP_MUL,   R_H,   R_H,   R_T1);
      6'd49:   u = mk(OP_SUB,   R_T2,  R_T1,  R_ONE);
      6'd50:   u = mk(OP_TEST,  R_T2,  R_T2,  R_H);
      default: u = mk(OP_TEST,  R_T2,  R_T2,  R_H);
    endcase
    return u;
  endfunction

  function automatic logic [31:0] int_to_float(logic [8:0] v);
    logic [3:0]  p;
    logic [22:0] w;
    logic [22:0] fr;
    p = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (v[i]) p = 4'(i);
    end
    w  = {v, 14'b0};
    fr = w << (4'd9 - p);
    return {1'b0, 8'd127 + {4'b0, p}, fr};
  endfunction

endpackage

@@ src/bcf_in_if.sv @@
// ----------------------------------------------------------------------------
// bcf_in_if
// Operand channel: valid/ready handshake carrying a, b and x.
// ----------------------------------------------------------------------------
interface bcf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] a_value;
  logic [31:0] b_value;
  logic [31:0] x_value;

  modport source(output valid, a_value, b_value, x_value, input ready);
  modport sink(input valid, a_value, b_value, x_value, output ready);
endinterface

@@ src/bcf_out_if.sv @@
// ----------------------------------------------------------------------------
// bcf_out_if
// Result channel: valid/ready handshake carrying h and status.
// ----------------------------------------------------------------------------
interface bcf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fraction_value;
  logic        not_converged;
  logic [7:0]  iterations_used;

  modport source(output valid, fraction_value, not_converged, iterations_used,
                 input ready);
  modport sink(input valid, fraction_value, not_converged, iterations_used,
               output ready);
endinterface

@@ src/bcf_fpu.sv @@
// ----------------------------------------------------------------------------
// bcf_fpu
// Shared single-precision unit: add, subtract, multiply, radix-2 divide,
// negate, tiny-value clamp, pass-through. Round to nearest even, subnormals supported.
// ----------------------------------------------------------------------------
module bcf_fpu import bcf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  fpu_req_t req,
  output fpu_rsp_t rsp
);

  typedef struct packed {
    logic              sign;
    logic              nan;
    logic              inf;
    logic              zero;
    logic signed [11:0] e;
    logic [23:0]       m;
  } unp_t;

  function automatic logic [4:0] lzc23(logic [22:0] v);
    logic [4:0] c;
    c = 5'd23;
    for (int i = 0; i < 23; i++) begin
      if (v[i]) c = 5'(22 - i);
    end
    return c;
  endfunction

  function automatic logic [5:0] lzc50(logic [49:0] v);
    logic [5:0] c;
    c = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (v[i]) c = 6'(49 - i);
    end
    return c;
  endfunction

  function automatic unp_t unpack(logic [31:0] f);
    unp_t       u;
    logic [4:0] sh;
    u.sign = f[31];
    u.nan  = (&f[30:23]) && (|f[22:0]);
    u.inf  = (&f[30:23]) && !(|f[22:0]);
    u.zero = !(|f[30:0]);
    sh     = lzc23(f[22:0]);
    if (|f[30:23]) begin
      u.e = $signed({4'b0, f[30:23]});
      u.m = {1'b1, f[22:0]};
    end else begin
      u.e = 12'sd0 - $signed({7'b0, sh});
      u.m = {1'b0, f[22:0]} << (sh + 5'd1);
    end
    return u;
  endfunction

  function automatic logic [31:0] round_pack(logic sgn, logic signed [11:0] e,
                                             logic [49:0] sig, logic sticky);
    logic [5:0]         lz;
    logic signed [11:0] nsh;
    logic signed [11:0] em1;
    logic signed [11:0] s;
    logic signed [11:0] en;
    logic [5:0]         ra;
    logic [49:0]        n;
    logic               st;
    logic               inc;
    logic [30:0]        r;
    logic [31:0]        res;
    lz  = lzc50(sig);
    nsh = $signed({6'b0, lz}) - 12'sd1;
    em1 = e - 12'sd1;
    if (em1 >= nsh) begin
      s  = nsh;
      en = e - nsh;
    end else begin
      s  = em1;
      en = 12'sd0;
    end
    st = sticky;
    ra = 6'd0;
    if (s >= 12'sd0) begin
      n = sig << s[5:0];
    end else begin
      if (s < -12'sd63) ra = 6'd63;
      else ra = 6'(-s);
      n  = sig >> ra;
      st = sticky | (|(sig & ~({50{1'b1}} << ra)));
    end
    inc = n[24] & (st | (|n[23:0]) | n[25]);
    r   = {en[7:0], n[47:25]} + {30'b0, inc};
    if (sig == '0) res = {sgn, 31'b0};
    else if (en >= 12'sd255) res = {sgn, 8'hFF, 23'b0};
    else res = {sgn, r};
    return res;
  endfunction

  fpu_state_t state;
  fpu_state_t state_next;

  op_t                st_op;
  logic [31:0]        st_a;
  logic [31:0]        st_b;
  unp_t               ua;
  unp_t               ub;
  logic               r_sign;
  logic signed [11:0] r_e;
  logic [49:0]        r_sig;
  logic               r_sticky;
  logic [25:0]        rem;
  logic [23:0]        dv;
  logic [26:0]        quo;
  logic [4:0]         cnt;
  logic [31:0]        result;

  // calculation stage results
  logic               c_direct;
  logic               c_div;
  logic [31:0]        c_res;
  logic               c_sign;
  logic signed [11:0] c_e;
  logic [49:0]        c_sig;

  logic               sb_eff;
  logic               swap;
  unp_t               big;
  unp_t               sml;
  logic               sgn_big;
  logic               sgn_sml;
  logic signed [11:0] ediff;
  logic [5:0]         dsh;
  logic [49:0]        a50;
  logic [49:0]        bfull;
  logic [49:0]        bj;
  logic [49:0]        sum;
  logic [47:0]        prod;
  logic               sx;
  logic               div_ge;

  always_comb begin
    c_direct = 1'b1;
    c_div    = 1'b0;
    c_res    = st_a;
    c_sign   = 1'b0;
    c_e      = 12'sd0;
    c_sig    = '0;
    sb_eff   = ub.sign ^ (st_op == OP_SUB);
    sx       = ua.sign ^ ub.sign;
    swap     = st_b[30:0] > st_a[30:0];
    big      = swap ? ub : ua;
    sml      = swap ? ua : ub;
    sgn_big  = swap ? sb_eff : ua.sign;
    sgn_sml  = swap ? ua.sign : sb_eff;
    ediff    = big.e - sml.e;
    dsh      = (ediff > 12'sd63) ? 6'd63 : ediff[5:0];
    a50      = {1'b0, big.m, 25'b0};
    bfull    = {1'b0, sml.m, 25'b0};
    bj       = (bfull >> dsh) | {49'b0, |(bfull & ~({50{1'b1}} << dsh))};
    sum      = (sgn_big == sgn_sml) ? a50 + bj : a50 - bj;
    prod     = ua.m * ub.m;
    case (st_op)
      OP_ADD, OP_SUB: begin
        if (ua.nan) c_res = st_a | FP_QUIET;
        else if (ub.nan) c_res = st_b | FP_QUIET;
        else if (ua.inf && ub.inf) c_res = (ua.sign != sb_eff) ? FP_DEFNAN : st_a;
        else if (ua.inf) c_res = st_a;
        else if (ub.inf) c_res = {sb_eff, st_b[30:0]};
        else if (ua.zero && ub.zero) c_res = {ua.sign & sb_eff, 31'b0};
        else if (sum == '0) c_res = 32'b0;
        else begin
          c_direct = 1'b0;
          c_sign   = sgn_big;
          c_e      = big.e;
          c_sig    = sum;
        end
      end
      OP_MUL: begin
        if (ua.nan) c_res = st_a | FP_QUIET;
        else if (ub.nan) c_res = st_b | FP_QUIET;
        else if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) c_res = FP_DEFNAN;
        else if (ua.inf || ub.inf) c_res = {sx, 8'hFF, 23'b0};
        else if (ua.zero || ub.zero) c_res = {sx, 31'b0};
        else begin
          c_direct = 1'b0;
          c_sign   = sx;
          c_e      = ua.e + ub.e - 12'sd127;
          c_sig    = {prod, 2'b0};
        end
      end
      OP_DIV: begin
        if (ub.zero) c_res = (ua.nan || ua.zero) ? FP_QNAN : {sx, 8'hFF, 23'b0};
        else if (ua.nan) c_res = st_a | FP_QUIET;
        else if (ub.nan) c_res = st_b | FP_QUIET;
        else if (ua.inf && ub.inf) c_res = FP_DEFNAN;
        else if (ua.inf) c_res = {sx, 8'hFF, 23'b0};
        else if (ub.inf || ua.zero) c_res = {sx, 31'b0};
        else begin
          c_direct = 1'b0;
          c_div    = 1'b1;
          c_sign   = sx;
          c_e      = ua.e - ub.e + 12'sd127;
        end
      end
      OP_NEG:   c_res = {~st_a[31], st_a[30:0]};
      OP_CLAMP: c_res = (st_a[30:0] < FP_TINY[30:0]) ? FP_TINY : st_a;
      OP_PASS:  c_res = st_a;
      default:  c_res = st_a;
    endcase
  end

  assign div_ge = rem >= {2'b0, dv};

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (req.start) state_next = F_UNPK;
      F_UNPK:  state_next = F_CALC;
      F_CALC: begin
        if (c_div) state_next = F_DIV;
        else if (c_direct) state_next = F_DONE;
        else state_next = F_ROUND;
      end
      F_DIV:   if (cnt == 5'd1) state_next = F_ROUND;
      F_ROUND: state_next = F_DONE;
      F_DONE:  state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    rsp.done   = (state == F_DONE);
    rsp.result = result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        F_IDLE: begin
          if (req.start) begin
            st_op <= req.op;
            st_a  <= req.opa;
            st_b  <= req.opb;
          end
        end
        F_UNPK: begin
          ua <= unpack(st_a);
          ub <= unpack(st_b);
        end
        F_CALC: begin
          result   <= c_res;
          r_sign   <= c_sign;
          r_e      <= c_e;
          r_sig    <= c_sig;
          r_sticky <= 1'b0;
          rem      <= {2'b0, ua.m};
          dv       <= ub.m;
          quo      <= '0;
          cnt      <= 5'd27;
        end
        F_DIV: begin
          quo <= {quo[25:0], div_ge};
          rem <= (div_ge ? rem - {2'b0, dv} : rem) << 1;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            r_sig    <= {1'b0, quo[25:0], div_ge, 22'b0};
            r_sticky <= ((div_ge ? rem - {2'b0, dv} : rem) != '0);
          end
        end
        F_ROUND: result <= round_pack(r_sign, r_e, r_sig, r_sticky);
        default: ;
      endcase
    end
  end

endmodule

@@ src/beta_continued_fraction_core.sv @@
// Runs N Lentz iterations per item, N = iterations used (1..100);
// special-valued operands let an add or multiply skip rounding, and a divide skip the divide loop too.
// One transaction at a time: a microcode sequencer drives one shared float unit
// through a 16-entry file; a new item is taken only once the core is back in idle.
// Reset (rst, synchronous) returns to idle; no state survives an item.
// ----------------------------------------------------------------------------
// beta_continued_fraction_core
// Modified Lentz evaluation of the incomplete-beta continued fraction.
// ----------------------------------------------------------------------------
module beta_continued_fraction_core import bcf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  bcf_in_if.sink   operands,
  bcf_out_if.source result
);

  seq_state_t      state;
  seq_state_t      state_next;
  logic [PC_W-1:0] pc;
  logic [7:0]      m;
  logic [31:0]     in_a;
  logic [31:0]     in_b;
  logic [31:0]     in_x;
  logic [31:0]     rf [16];
  logic [31:0]     rd_a;
  logic [31:0]     rd_b;
  logic [31:0]     fraction;
  logic            not_conv;
  logic [7:0]      iters;

  uop_t            uop;
  logic            is_load;
  logic            conv;
  logic            finish;
  logic            rf_we;
  logic [31:0]     rf_wd;
  logic [31:0]     ld_val;
  fpu_req_t        fpu_req;
  fpu_rsp_t        fpu_rsp;

  bcf_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (fpu_req),
    .rsp (fpu_rsp)
  );

  assign uop     = prog_rom(pc);
  assign is_load = uop.op inside {OP_LDA, OP_LDB, OP_LDX, OP_LDONE, OP_LDFM, OP_LDFM2};
  assign conv    = rd_a[30:0] < FP_EPS[30:0];
  assign finish  = conv || (m == MAX_ITERATIONS);

  always_comb begin
    case (uop.op)
      OP_LDA:   ld_val = in_a;
      OP_LDB:   ld_val = in_b;
      OP_LDX:   ld_val = in_x;
      OP_LDONE: ld_val = FP_ONE;
      OP_LDFM:  ld_val = int_to_float({1'b0, m});
      OP_LDFM2: ld_val = int_to_float({m, 1'b0});
      default:  ld_val = FP_ONE;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (operands.valid) state_next = S_ISSUE;
      S_ISSUE: if (!is_load) state_next = S_READ;
      S_READ: begin
        if (uop.op == OP_TEST) state_next = finish ? S_OUT : S_ISSUE;
        else state_next = S_WAIT;
      end
      S_WAIT:  if (fpu_rsp.done) state_next = S_ISSUE;
      S_OUT:   if (result.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    operands.ready         = (state == S_IDLE);
    result.valid           = (state == S_OUT);
    result.fraction_value  = fraction;
    result.not_converged   = not_conv;
    result.iterations_used = iters;
    fpu_req.start          = (state == S_READ) && (uop.op != OP_TEST);
    fpu_req.op             = uop.op;
    fpu_req.opa            = rd_a;
    fpu_req.opb            = rd_b;
    rf_we                  = ((state == S_ISSUE) && is_load) ||
                             ((state == S_WAIT) && fpu_rsp.done);
    rf_wd                  = (state == S_WAIT) ? fpu_rsp.result : ld_val;
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[uop.dst] <= rf_wd;
    rd_a <= rf[uop.sa];
    rd_b <= rf[uop.sb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      m     <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (operands.valid) begin
            pc   <= '0;
            m    <= 8'd1;
            in_a <= operands.a_value;
            in_b <= operands.b_value;
            in_x <= operands.x_value;
          end
        end
        S_ISSUE: if (is_load) pc <= pc + 1'b1;
        S_READ: begin
          if (uop.op == OP_TEST) begin
            if (finish) begin
              fraction <= rd_b;
              not_conv <= !conv;
              iters    <= m;
            end else begin
              pc <= LOOP_PC;
              m  <= m + 8'd1;
            end
          end
        end
        S_WAIT: if (fpu_rsp.done) pc <= pc + 1'b1;
        default: ;
      endcase
    end
  end

endmodule
